// File: src/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; mlr_front, mlr_back and the top level import this package.
package mlr_pkg;

  // Item function code carried on the func field.
  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  // Depth of the command queue and of the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// File: src/mlr_fifo.sv
// Small synchronous queue used for the command and result words.
// Depends on nothing but its parameters; DEPTH must be at least two.
module mlr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok;
  logic             pop_ok;

  // Status comes straight from the registered count.
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // Pointer and count updates, with wrap at the last entry.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  // The count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  // A lone pop removes exactly one word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok && !push_ok |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("queue count did not drop on pop");

  // A lone push always leaves a word to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok && !pop_ok |=> !empty_o)
    else $error("queue empty after push");

endmodule

// File: src/mlr_front.sv
// Front end: classifies an incoming word and works out the line setup
// for a load. Depends on mlr_pkg.
module mlr_front #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                    func_i,
  input  logic [COORD_BITS-1:0]   start_x_i,
  input  logic [COORD_BITS-1:0]   start_y_i,
  input  logic [COORD_BITS-1:0]   end_x_i,
  input  logic [COORD_BITS-1:0]   end_y_i,
  output logic [6*COORD_BITS+9:0] cmd_o
);
  import mlr_pkg::*;

  localparam int unsigned C = COORD_BITS;

  typedef struct packed {
    func_e             func;
    logic [C-1:0]      x;
    logic [C-1:0]      y;
    logic [C-1:0]      major_end;
    logic [C+2:0]      decision;
    logic [C+1:0]      step_inc;
    logic [C:0]        hold_dec;
    logic              minor_down;
    logic              major_is_x;
    logic              active;
  } cmd_t;

  cmd_t         cmd;
  logic [C-1:0] dx, dy;
  logic         major_is_x;
  logic [C-1:0] mj0, mj1, mn0, mn1;
  logic [C-1:0] lo_mj, hi_mj, lo_mn, hi_mn;
  logic [C-1:0] dmaj, dmin;

  // Absolute deltas on both axes.
  assign dx = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign dy = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;

  // The x axis is major only when its delta is strictly larger.
  assign major_is_x = (dx > dy);

  // Map the endpoints onto major and minor axes.
  always_comb begin
    if (major_is_x) begin
      mj0  = start_x_i;
      mj1  = end_x_i;
      mn0  = start_y_i;
      mn1  = end_y_i;
      dmaj = dx;
      dmin = dy;
    end else begin
      mj0  = start_y_i;
      mj1  = end_y_i;
      mn0  = start_x_i;
      mn1  = end_x_i;
      dmaj = dy;
      dmin = dx;
    end
  end

  // Order the endpoints so that the major coordinate rises.
  always_comb begin
    if (mj0 > mj1) begin
      lo_mj = mj1;
      hi_mj = mj0;
      lo_mn = mn1;
      hi_mn = mn0;
    end else begin
      lo_mj = mj0;
      hi_mj = mj1;
      lo_mn = mn0;
      hi_mn = mn1;
    end
  end

  // Build the command word, including decision setup and increments.
  always_comb begin
    cmd.func       = func_e'(func_i);
    cmd.x          = major_is_x ? lo_mj : lo_mn;
    cmd.y          = major_is_x ? lo_mn : lo_mj;
    cmd.major_end  = hi_mj;
    cmd.decision   = {3'b000, dmaj} - {2'b00, dmin, 1'b0};
    cmd.step_inc   = {1'b0, dmaj, 1'b0} - {1'b0, dmin, 1'b0};
    cmd.hold_dec   = {dmin, 1'b0};
    cmd.minor_down = !(hi_mn > lo_mn);
    cmd.major_is_x = major_is_x;
    cmd.active     = (lo_mj != hi_mj);
  end

  assign cmd_o = cmd;

endmodule

// File: src/mlr_back.sv
// Back end: holds the line state, loads it on a load word and steps it one pixel
// per advance word while a line is in progress. Depends on mlr_pkg and the command layout of mlr_front.
module mlr_back #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  logic [6*COORD_BITS+9:0] cmd_i,
  output logic                    cmd_take_o,
  input  logic                    res_full_i,
  output logic                    res_push_o,
  output logic [2*COORD_BITS+1:0] res_o
);
  import mlr_pkg::*;

  localparam int unsigned C = COORD_BITS;

  typedef struct packed {
    func_e             func;
    logic [C-1:0]      x;
    logic [C-1:0]      y;
    logic [C-1:0]      major_end;
    logic [C+2:0]      decision;
    logic [C+1:0]      step_inc;
    logic [C:0]        hold_dec;
    logic              minor_down;
    logic              major_is_x;
    logic              active;
  } cmd_t;

  typedef struct packed {
    logic [C-1:0] x;
    logic [C-1:0] y;
    logic         valid;
    logic         last;
  } res_t;

  cmd_t         cmd;
  res_t         res;
  logic         take;

  logic [C-1:0] cur_x_q, cur_x_d;
  logic [C-1:0] cur_y_q, cur_y_d;
  logic [C-1:0] major_end_q, major_end_d;
  logic [C+2:0] decision_q, decision_d;
  logic [C+1:0] step_inc_q, step_inc_d;
  logic [C:0]   hold_dec_q, hold_dec_d;
  logic         minor_down_q, minor_down_d;
  logic         major_is_x_q, major_is_x_d;
  logic         active_q, active_d;

  logic [C-1:0] mj, mn, mj_nxt, mn_nxt;
  logic         dec_neg;

  assign cmd        = cmd_t'(cmd_i);
  assign take       = cmd_valid_i && !res_full_i;
  assign cmd_take_o = take;
  assign res_push_o = take;
  assign res_o      = res;

  // One step of the midpoint walk on the registered state.
  assign mj      = major_is_x_q ? cur_x_q : cur_y_q;
  assign mn      = major_is_x_q ? cur_y_q : cur_x_q;
  assign dec_neg = decision_q[C+2];
  assign mj_nxt  = mj + C'(1);
  always_comb begin
    if (!dec_neg) begin
      mn_nxt = mn;
    end else if (minor_down_q) begin
      mn_nxt = mn - C'(1);
    end else begin
      mn_nxt = mn + C'(1);
    end
  end

  // Next state for a load, an advance, or an advance while idle.
  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    major_end_d  = major_end_q;
    decision_d   = decision_q;
    step_inc_d   = step_inc_q;
    hold_dec_d   = hold_dec_q;
    minor_down_d = minor_down_q;
    major_is_x_d = major_is_x_q;
    active_d     = active_q;
    if (take) begin
      if (cmd.func == FUNC_LOAD) begin
        cur_x_d      = cmd.x;
        cur_y_d      = cmd.y;
        major_end_d  = cmd.major_end;
        decision_d   = cmd.decision;
        step_inc_d   = cmd.step_inc;
        hold_dec_d   = cmd.hold_dec;
        minor_down_d = cmd.minor_down;
        major_is_x_d = cmd.major_is_x;
        active_d     = cmd.active;
      end else if (active_q) begin
        cur_x_d    = major_is_x_q ? mj_nxt : mn_nxt;
        cur_y_d    = major_is_x_q ? mn_nxt : mj_nxt;
        decision_d = dec_neg ? decision_q + {1'b0, step_inc_q}
                             : decision_q - {2'b00, hold_dec_q};
        active_d   = (mj_nxt != major_end_q);
      end
    end
  end

  // Result word: the pixel after the update, or zeros when idle.
  always_comb begin
    if (cmd.func == FUNC_LOAD || active_q) begin
      res.x     = cur_x_d;
      res.y     = cur_y_d;
      res.valid = 1'b1;
      res.last  = !active_d;
    end else begin
      res.x     = '0;
      res.y     = '0;
      res.valid = 1'b0;
      res.last  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      major_end_q  <= '0;
      decision_q   <= '0;
      step_inc_q   <= '0;
      hold_dec_q   <= '0;
      minor_down_q <= 1'b0;
      major_is_x_q <= 1'b1;
      active_q     <= 1'b0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      major_end_q  <= major_end_d;
      decision_q   <= decision_d;
      step_inc_q   <= step_inc_d;
      hold_dec_q   <= hold_dec_d;
      minor_down_q <= minor_down_d;
      major_is_x_q <= major_is_x_d;
      active_q     <= active_d;
    end
  end

  // A line can only start through a load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> $past(take) && $past(cmd.func) == FUNC_LOAD)
    else $error("line became active without a load");

  // An advance while idle changes no pixel state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd.func == FUNC_ADVANCE && !active_q |=>
      $stable(cur_x_q) && $stable(cur_y_q) && !active_q)
    else $error("idle advance changed the state");

  // The last flag is raised only on a real pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res.last |-> res.valid)
    else $error("last flag on an invalid result");

endmodule

// File: src/midpoint_line_rasterizer.sv
// Top level of the midpoint line rasterizer: command queue, setup front end,
// stepping back end and result queue. Depends on mlr_pkg and all src modules.
//
// Usage: push a load word (func 0) with two endpoints to get the first pixel
// of a segment, then one advance word (func 1) per further pixel; the pixel
// that reaches the far end of the major axis comes out with last set, and an
// advance with no line in progress returns a word with pixel_valid low and
// zero coordinates. A load at any time drops the line in progress. Every
// accepted word yields exactly one result word, in order. The block takes one
// word per clock and returns one per clock while results are popped; a word is
// registered in the command queue and its result in the result queue before
// it shows on the result ports. The pace is set by the back end, which updates
// the decision value and the current pixel on each taken advance word, with a
// two-word queue on each side so input and output stall independently.
module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  pixel_valid_o,
  output logic                  last_o
);
  import mlr_pkg::*;

  localparam int unsigned CMD_W = 6 * COORD_BITS + 10;
  localparam int unsigned RES_W = 2 * COORD_BITS + 2;

  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic             cmd_empty;
  logic             cmd_take;
  logic [RES_W-1:0] res_in;
  logic [RES_W-1:0] res_out;
  logic             res_full;
  logic             res_push;

  // Setup for a load is worked out before the word enters the queue.
  mlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .func_i   (func_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i  (end_x_i),
    .end_y_i  (end_y_i),
    .cmd_o    (cmd_in)
  );

  // Command queue between front and back.
  mlr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_take),
    .data_o (cmd_out),
    .empty_o(cmd_empty)
  );

  // Line stepper.
  mlr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_take_o (cmd_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue toward the consumer.
  mlr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  // Result word layout: x, y, valid, last from the top bit down.
  assign pixel_x_o     = res_out[RES_W-1 -: COORD_BITS];
  assign pixel_y_o     = res_out[COORD_BITS+1 -: COORD_BITS];
  assign pixel_valid_o = res_out[1];
  assign last_o        = res_out[0];

endmodule
